[rtl/mbmg_pkg.sv]
// ----------------------------------------------------------------------------
// mbmg_pkg: shared types and codes of the masked box mean grid
// Item structs of both channels, request codes and configuration indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mbmg_pkg;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS     = 2'd2;

  // configuration widths and reset values
  localparam int CFG_DATA_W = 7;
  localparam int RADIUS_W   = 3;
  localparam int DIM_W      = 7;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 3'd3;
  localparam logic [DIM_W-1:0]    DIM_RST    = 7'd64;

  // field widths
  localparam int POS_W    = 6;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 8;

  // width for window bound arithmetic (covers coordinates up to 2047)
  localparam int COORD_W = 11;

  typedef struct packed {
    logic                       req_type;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic                       mean_valid;
    logic [COUNT_W-1:0]         valid_count;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/masked_box_mean_grid.sv]
// ----------------------------------------------------------------------------
// masked_box_mean_grid: masked box-filter mean over a sample grid
// Loads write one sample with its valid flag into the grid store; queries
// average the valid samples in a clipped square window around a centre.
// ----------------------------------------------------------------------------
//
//  channel   ports                          item
//  -------   ----------------------------   ---------------------------------
//  input     in_valid / in_ready / in_item  load sample or query centre
//  result    out_valid/out_ready/out_item   mean, mean flag, valid count
//  config    cfg_wr_en/cfg_index/cfg_wdata  radius, rows, columns
//
//  A query reads the clipped window cells, one store read per cycle, then
//  divides the sum, one divider step per cycle for each bit of the sum width.
//  Reset clears control state only; the store is undefined until written.
//  in_ready is low while a query runs; a finished result waits in the output
//  register, and a further query stalls only at its end if it is still full.
//
`default_nettype none

module masked_box_mean_grid #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire mbmg_pkg::in_item_t                   in_item,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output mbmg_pkg::out_item_t                       out_item,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [mbmg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mbmg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import mbmg_pkg::*;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW     = ROW_W + COL_W;
  localparam int DEPTH  = 1 << AW;
  localparam int CELLS  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_DIVGO = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [RADIUS_W-1:0] radius_r;
  logic [DIM_W-1:0]    rows_r;
  logic [DIM_W-1:0]    cols_r;

  logic [SAMPLE_W:0]   mem [DEPTH];
  logic [SAMPLE_W:0]   rd_data_r;
  logic                rd_vld_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  logic [ROW_W-1:0]    i_r, i_nxt, r1_r;
  logic [COL_W-1:0]    j_r, j_nxt, c0_r, c1_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                out_valid_r;
  out_item_t           out_item_r;

  // window bounds
  logic [COORD_W-1:0]  nr, nc, rad, row_w, col_w;
  logic [COORD_W-1:0]  r0, r1, c0, c1, r_hi, c_hi;
  logic                win_empty;
  logic                in_acc, is_load, is_query, load_ok, scan_last;

  logic [SUM_W-1:0]    sum_mag;
  logic                div_done;
  logic [SUM_W-1:0]    quo;
  logic [SAMPLE_W-1:0] mean_mag, mean_fix;
  logic [CNT_W+7:0]    cnt_ext;
  logic [COUNT_W-1:0]  cnt_sat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign is_load  = in_acc && (in_item.req_type == REQ_LOAD);
  assign is_query = in_acc && (in_item.req_type == REQ_QUERY);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      rows_r   <= DIM_RST;
      cols_r   <= DIM_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SMOOTH_RADIUS: radius_r <= cfg_wdata[RADIUS_W-1:0];
        CFG_GRID_ROWS:     rows_r   <= cfg_wdata[DIM_W-1:0];
        CFG_GRID_COLS:     cols_r   <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes and radius, clip the window to the grid in use
  always_comb begin
    if (rows_r == '0) nr = COORD_W'(1);
    else if (COORD_W'(rows_r) > COORD_W'(MAX_ROWS)) nr = COORD_W'(MAX_ROWS);
    else nr = COORD_W'(rows_r);
    if (cols_r == '0) nc = COORD_W'(1);
    else if (COORD_W'(cols_r) > COORD_W'(MAX_COLS)) nc = COORD_W'(MAX_COLS);
    else nc = COORD_W'(cols_r);
    if (COORD_W'(radius_r) > COORD_W'(MAX_RADIUS)) rad = COORD_W'(MAX_RADIUS);
    else rad = COORD_W'(radius_r);
    row_w = COORD_W'(in_item.row);
    col_w = COORD_W'(in_item.col);
    r0    = (row_w < rad) ? '0 : row_w - rad;
    c0    = (col_w < rad) ? '0 : col_w - rad;
    r_hi  = row_w + rad;
    c_hi  = col_w + rad;
    r1    = (r_hi > nr - 1'b1) ? nr - 1'b1 : r_hi;
    c1    = (c_hi > nc - 1'b1) ? nc - 1'b1 : c_hi;
    win_empty = (r0 > r1) || (c0 > c1);
    load_ok   = (row_w < COORD_W'(MAX_ROWS)) && (col_w < COORD_W'(MAX_COLS));
  end

  // scan address walk, row by row
  assign rd_en     = (state_r == ST_SCAN);
  assign rd_addr   = {i_r, j_r};
  assign scan_last = (i_r == r1_r) && (j_r == c1_r);

  always_comb begin
    if (j_r == c1_r) begin
      j_nxt = c0_r;
      i_nxt = i_r + 1'b1;
    end else begin
      j_nxt = j_r + 1'b1;
      i_nxt = i_r;
    end
  end

  // grid store: write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (is_load && load_ok) begin
      mem[{row_w[ROW_W-1:0], col_w[COL_W-1:0]}] <= {in_item.sample_valid, in_item.sample};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (is_query) state_nxt = win_empty ? ST_FIN : ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = (cnt_r == '0) ? ST_FIN : ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_FIN;
      ST_FIN:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // window registers and accumulation
  always_ff @(posedge clk) begin
    if (is_query) begin
      i_r   <= r0[ROW_W-1:0];
      r1_r  <= r1[ROW_W-1:0];
      j_r   <= c0[COL_W-1:0];
      c0_r  <= c0[COL_W-1:0];
      c1_r  <= c1[COL_W-1:0];
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (rd_en) begin
        i_r <= i_nxt;
        j_r <= j_nxt;
      end
      if (rd_vld_r && rd_data_r[SAMPLE_W]) begin
        sum_r <= sum_r + {{CNT_W{rd_data_r[SAMPLE_W-1]}}, rd_data_r[SAMPLE_W-1:0]};
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // divide the magnitude of the sum by the count
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  mbmg_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == ST_DIVGO) && (cnt_r != '0)),
    .dividend (sum_mag),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quo)
  );

  // restore the sign, saturate the count
  assign mean_mag = quo[SAMPLE_W-1:0];
  assign mean_fix = sum_r[SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
  assign cnt_ext  = (CNT_W + 8)'(cnt_r);
  assign cnt_sat  = (cnt_ext > (CNT_W + 8)'(255)) ? 8'hFF : cnt_ext[COUNT_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && (!out_valid_r || out_ready)) begin
      out_item_r.mean_value  <= (cnt_r == '0) ? '0 : mean_fix;
      out_item_r.mean_valid  <= (cnt_r != '0);
      out_item_r.valid_count <= cnt_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[rtl/mbmg_div.sv]
// ----------------------------------------------------------------------------
// mbmg_div: iterative unsigned restoring divider
// One quotient bit per cycle; done pulses once after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module mbmg_div #(
  parameter int DW = 24,
  parameter int VW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[VW-1:0] : trial[VW-1:0];
    quo_nxt = {quo_r[DW-2:0], fits};
  end

  // control: run for DW steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: load operands, then step
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/mbmg_checker.sv]
// ----------------------------------------------------------------------------
// mbmg_checker: port-level assertions for the masked box mean grid
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module mbmg_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire mbmg_pkg::in_item_t              in_item,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire mbmg_pkg::out_item_t             out_item
);

  import mbmg_pkg::*;

  // block comes out of reset ready for an item
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // a query occupies the block for at least the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.req_type == REQ_QUERY) |=> !in_ready)
    else $error("query accepted without going busy");

  // result flag agrees with count and missing results carry zero
  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.mean_valid == (out_item.valid_count != '0)) &&
                   (out_item.mean_valid || out_item.mean_value == '0)))
    else $error("result flag, count and value disagree");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind masked_box_mean_grid mbmg_checker u_mbmg_checker (.*);

`default_nettype wire

[bench/tb_masked_box_mean_grid.sv]
// ----------------------------------------------------------------------------
// tb_masked_box_mean_grid: self-checking bench for the masked box mean grid
// Loads samples and queries window means through the valid/ready channels,
// predicts every result from a bench-side copy of the grid and registers,
// and compares each returned item field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_masked_box_mean_grid;
  timeunit 1ns;
  timeprecision 1ps;

  import mbmg_pkg::*;

  localparam int GRID_MAX      = 64;
  localparam int CELLS         = GRID_MAX * GRID_MAX;
  localparam int STALL_PCT     = 71;
  localparam int BOTH_PCT      = 38;
  localparam int HOLD_CYCLES   = 1000;
  localparam int QUIET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 300;
  localparam int PHASE_ITEMS   = 25;
  localparam int PHASE_QUERIES = 6;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SRC_IDLE,
    PACE_SINK_STALL,
    PACE_BOTH
  } pace_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // bench copy of the grid store and the registers
  logic signed [SAMPLE_W-1:0] cell_val [CELLS];
  bit                         cell_ok [CELLS];
  bit                         cell_loaded [CELLS];
  logic [RADIUS_W-1:0]        radius_m = RADIUS_RST;
  logic [DIM_W-1:0]           rows_m = DIM_RST;
  logic [DIM_W-1:0]           cols_m = DIM_RST;

  in_item_t  pending_items [$];
  out_item_t mean_q [$];
  int        err_count = 0;
  bit        in_took = 1'b0;
  pace_t     pace = PACE_FULL;
  bit        hold_req = 1'b0;
  bit        hold_seen = 1'b0;
  int        hold_left = 0;

  masked_box_mean_grid uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clip the window around a centre to the grid in use
  function automatic void clip_window(input int r, input int c,
                                      output int r0, output int r1,
                                      output int c0, output int c1);
    int nr;
    int nc;
    int rad;
    nr  = (rows_m == 0) ? 1 : (rows_m > GRID_MAX) ? GRID_MAX : int'(rows_m);
    nc  = (cols_m == 0) ? 1 : (cols_m > GRID_MAX) ? GRID_MAX : int'(cols_m);
    rad = int'(radius_m);
    r0  = (r - rad < 0) ? 0 : r - rad;
    r1  = (r + rad > nr - 1) ? nr - 1 : r + rad;
    c0  = (c - rad < 0) ? 0 : c - rad;
    c1  = (c + rad > nc - 1) ? nc - 1 : c + rad;
  endfunction

  // average the valid cells of the clipped window, truncating toward zero
  function automatic out_item_t box_mean(input int r, input int c);
    out_item_t res;
    int r0, r1, c0, c1;
    int total;
    int n;
    total = 0;
    n     = 0;
    clip_window(r, c, r0, r1, c0, c1);
    for (int i = r0; i <= r1; i++) begin
      for (int j = c0; j <= c1; j++) begin
        if (cell_ok[i * GRID_MAX + j]) begin
          total += int'(cell_val[i * GRID_MAX + j]);
          n++;
        end
      end
    end
    res.mean_value  = (n > 0) ? SAMPLE_W'(total / n) : '0;
    res.mean_valid  = (n > 0);
    res.valid_count = (n > 255) ? 8'd255 : COUNT_W'(n);
    return res;
  endfunction

  // apply accepted items to the bench grid and check returned results
  always @(posedge clk) begin : result_check
    out_item_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      if (in_item.req_type == REQ_LOAD) begin
        cell_val[int'(in_item.row) * GRID_MAX + in_item.col] = in_item.sample;
        cell_ok[int'(in_item.row) * GRID_MAX + in_item.col]  = in_item.sample_valid;
      end else begin
        mean_q.push_back(box_mean(in_item.row, in_item.col));
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        $error("result with no query waiting: mean_value %0d count %0d",
               out_item.mean_value, out_item.valid_count);
        err_count++;
      end else begin
        want = mean_q.pop_front();
        if (out_item.mean_value !== want.mean_value) begin
          $error("mean_value: expected %0d, got %0d", want.mean_value,
                 out_item.mean_value);
          err_count++;
        end
        if (out_item.mean_valid !== want.mean_valid) begin
          $error("mean_valid: expected %0d, got %0d", want.mean_valid,
                 out_item.mean_valid);
          err_count++;
        end
        if (out_item.valid_count !== want.valid_count) begin
          $error("valid_count: expected %0d, got %0d", want.valid_count,
                 out_item.valid_count);
          err_count++;
        end
      end
    end
  end

  // offer pending items; hold each one until it is taken
  always @(negedge clk) begin : item_driver
    int gap;
    gap = (pace == PACE_SRC_IDLE) ? STALL_PCT : (pace == PACE_BOTH) ? BOTH_PCT : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= gap) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // pace the result side; one long hold-off fills the block up
  always @(negedge clk) begin : sink_pace
    int stall;
    stall = (pace == PACE_SINK_STALL) ? STALL_PCT : (pace == PACE_BOTH) ? BOTH_PCT : 0;
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(19))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_load(input int r, input int c,
                           input logic signed [SAMPLE_W-1:0] s, input bit ok);
    in_item_t it;
    it.req_type     = REQ_LOAD;
    it.row          = POS_W'(r);
    it.col          = POS_W'(c);
    it.sample       = s;
    it.sample_valid = ok;
    pending_items.push_back(it);
    cell_loaded[r * GRID_MAX + c] = 1'b1;
  endtask

  task automatic push_query(input int r, input int c);
    in_item_t it;
    it.req_type     = REQ_QUERY;
    it.row          = POS_W'(r);
    it.col          = POS_W'(c);
    it.sample       = SAMPLE_W'($urandom);
    it.sample_valid = $urandom_range(1);
    pending_items.push_back(it);
  endtask

  // load every never-written cell of the window first, then query it
  task automatic fill_and_query(input int r, input int c, input int valid_pct,
                                inout int n_items);
    int r0, r1, c0, c1;
    clip_window(r, c, r0, r1, c0, c1);
    for (int i = r0; i <= r1; i++) begin
      for (int j = c0; j <= c1; j++) begin
        if (!cell_loaded[i * GRID_MAX + j]) begin
          push_load(i, j, pick_sample(), $urandom_range(99) < valid_pct);
          n_items++;
        end
      end
    end
    push_query(r, c);
    n_items++;
  endtask

  // wait until nothing is queued, offered or expected
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || mean_q.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_SMOOTH_RADIUS: radius_m = data[RADIUS_W-1:0];
      CFG_GRID_ROWS:     rows_m   = data[DIM_W-1:0];
      CFG_GRID_COLS:     cols_m   = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] rad,
                            input logic [CFG_DATA_W-1:0] rows,
                            input logic [CFG_DATA_W-1:0] cols, input pace_t p);
    wait_idle();
    write_reg(CFG_SMOOTH_RADIUS, rad);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    pace = p;
  endtask

  // random mix of stray loads and window queries around a drifting centre
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rad,
                           input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] cols, input pace_t p,
                           input int valid_pct, input int hot_r, input int hot_c,
                           input bit squeeze);
    int n_items;
    int n_queries;
    int r;
    int c;
    set_config(rad, rows, cols, p);
    if (squeeze) hold_req = 1'b1;
    n_items   = 0;
    n_queries = 0;
    while (n_items < PHASE_ITEMS || n_queries < PHASE_QUERIES) begin
      if ($urandom_range(9) < 3) begin
        push_load($urandom_range(GRID_MAX - 1), $urandom_range(GRID_MAX - 1),
                  pick_sample(), $urandom_range(99) < valid_pct);
        n_items++;
      end else begin
        if ($urandom_range(9) < 6) begin
          r = hot_r + int'($urandom_range(6)) - 3;
          c = hot_c + int'($urandom_range(6)) - 3;
          r = (r < 0) ? 0 : (r > GRID_MAX - 1) ? GRID_MAX - 1 : r;
          c = (c < 0) ? 0 : (c > GRID_MAX - 1) ? GRID_MAX - 1 : c;
        end else begin
          r = $urandom_range(GRID_MAX - 1);
          c = $urandom_range(GRID_MAX - 1);
        end
        fill_and_query(r, c, valid_pct, n_items);
        n_queries++;
        hot_r = r;
        hot_c = c;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 2x2 grid, widest radius: full-scale sums, truncation, masking, clipping
    set_config(7, 2, 2, PACE_FULL);
    push_load(0, 0, 16'sh7FFF, 1'b1);
    push_load(0, 1, 16'sh7FFF, 1'b1);
    push_load(1, 0, 16'sh7FFF, 1'b1);
    push_load(1, 1, 16'sh7FFF, 1'b1);
    push_query(0, 0);
    push_load(1, 1, 16'sh8000, 1'b1);
    push_query(1, 1);
    push_load(0, 0, 16'sh8000, 1'b1);
    push_load(0, 1, 16'sh8000, 1'b1);
    push_load(1, 0, -16'sd7, 1'b1);
    push_query(1, 0);
    push_load(0, 1, 16'sd5, 1'b0);
    push_query(0, 0);
    push_load(63, 63, 16'sd12345, 1'b1);
    push_query(63, 63);
    push_query(2, 2);
    push_load(0, 0, -16'sd1, 1'b0);
    push_load(1, 0, 16'sh5555, 1'b0);
    push_load(1, 1, 16'shAAAA, 1'b0);
    push_query(1, 0);

    // zero-sized grid acts as one cell, zero radius
    set_config(0, 0, 0, PACE_SRC_IDLE);
    push_load(0, 0, -16'sd1, 1'b1);
    push_query(0, 0);
    push_query(0, 63);
    push_query(63, 0);

    // random phases over a spread of radii, grid sizes and pacing;
    // the widest radius runs on a 15x15 grid so full windows stay cheap to fill
    run_phase(3, 8, 8, PACE_FULL, 80, 4, 4, 1'b0);
    run_phase(1, 5, 12, PACE_SRC_IDLE, 80, 2, 6, 1'b0);
    run_phase(7, 15, 15, PACE_FULL, 100, 7, 7, 1'b1);
    run_phase(2, 16, 3, PACE_SINK_STALL, 60, 8, 1, 1'b0);
    run_phase(1, 127, 100, PACE_BOTH, 80, 30, 60, 1'b0);
    run_phase(0, 1, 64, PACE_SINK_STALL, 70, 0, 20, 1'b0);
    run_phase($urandom_range(7), $urandom_range(16), $urandom_range(16),
              PACE_BOTH, 75, $urandom_range(63), $urandom_range(63), 1'b0);
    run_phase(7'h7A, 65, 33, PACE_SRC_IDLE, 80, 10, 10, 1'b0);
    run_phase(5, 64, 1, PACE_FULL, 85, 20, 0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
